### design/aac_pkg.sv
// Shared widths, constants and state encoding for the airspeed average and convert unit.
package aac_pkg;

	// Fixed field widths
	localparam int ADC_W   = 12;
	localparam int SPEED_W = 14;
	localparam int DEV_W   = 12;
	localparam int SCALE_W = 16;
	localparam int PROD_W  = DEV_W + SCALE_W;

	// Scale register reset, about 0.0793 in Q0.16
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd5199;
	// Deviation clamp
	localparam logic [DEV_W-1:0] DEV_MAX = 12'd4095;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;

	// Iteration steps handled per clock by the square root unit
	localparam int SQRT_STEPS = 2;
	localparam int SQRT_CYC   = SPEED_W / SQRT_STEPS;
	localparam int SQRT_CNT_W = 3;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_MEAN,
		S_DIFF,
		S_DEV,
		S_ROOT_LOAD,
		S_ROOT,
		S_OUT
	} back_state_t;

endpackage

### design/aac_front.sv
// Input side: accepts items, classifies them and queues them for the back end.
module aac_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      action,
	input  logic [aac_pkg::ADC_W-1:0] adc_sample,
	output logic                      cmd_valid,
	output logic                      cmd_capture,
	output logic [SAMPLE_BITS-1:0]    cmd_sample,
	input  logic                      cmd_take
);
	import aac_pkg::*;

	localparam int ENTRY_W = SAMPLE_BITS + 1;

	logic [ADC_W+SAMPLE_BITS-1:0] sample_wide;
	logic [SAMPLE_BITS-1:0]       sample_masked;
	logic [ENTRY_W-1:0]           entry_in;
	logic [ENTRY_W-1:0]           fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]        wr_ptr_q;
	logic [FIFO_PTR_W-1:0]        rd_ptr_q;
	logic [FIFO_PTR_W:0]          count_q;
	logic                         wr_en;
	logic                         rd_en;

	// Classify: keep only the sample bits the window holds, drop the sample for a capture
	assign sample_wide   = {{SAMPLE_BITS{1'b0}}, adc_sample};
	assign sample_masked = sample_wide[SAMPLE_BITS-1:0];
	assign entry_in      = {action, action ? {SAMPLE_BITS{1'b0}} : sample_masked};

	assign full      = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	assign cmd_capture = fifo_q[rd_ptr_q][ENTRY_W-1];
	assign cmd_sample  = fifo_q[rd_ptr_q][SAMPLE_BITS-1:0];

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= entry_in;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/aac_sqrt.sv
// Iterative integer square root, two result bits per clock.
module aac_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [aac_pkg::PROD_W-1:0]  radicand,
	output logic                        busy,
	output logic [aac_pkg::SPEED_W-1:0] root
);
	import aac_pkg::*;

	localparam int REM_W = SPEED_W + 2;

	logic [PROD_W-1:0]     rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [SPEED_W-1:0]    root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;

	logic [PROD_W-1:0]  rad_nx;
	logic [REM_W-1:0]   rem_nx;
	logic [SPEED_W-1:0] root_nx;
	logic [REM_W-1:0]   trial;

	// Two restoring digit steps: bring in two radicand bits, try 4*root+1
	always_comb begin
		rad_nx  = rad_q;
		rem_nx  = rem_q;
		root_nx = root_q;
		trial   = '0;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			rem_nx = {rem_nx[SPEED_W-1:0], rad_nx[PROD_W-1:PROD_W-2]};
			rad_nx = {rad_nx[PROD_W-3:0], 2'b00};
			trial  = {root_nx, 2'b01};
			if (rem_nx >= trial) begin
				rem_nx  = rem_nx - trial;
				root_nx = {root_nx[SPEED_W-2:0], 1'b1};
			end else begin
				root_nx = {root_nx[SPEED_W-2:0], 1'b0};
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_nx;
			rem_q  <= rem_nx;
			root_q <= root_nx;
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == SQRT_CNT_W'(SQRT_CYC - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

### design/aac_back.sv
// Back end: sample window, zero offset, mean and deviation division, square root, result buffer.
module aac_back #(
	parameter int WINDOW_LENGTH = 20,
	parameter int SAMPLE_BITS   = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  logic                        cmd_capture,
	input  logic [SAMPLE_BITS-1:0]      cmd_sample,
	output logic                        cmd_take,
	input  logic [aac_pkg::SCALE_W-1:0] scale,
	output logic                        empty,
	input  logic                        pop,
	output logic [aac_pkg::SPEED_W-1:0] airspeed_q8_8,
	output logic [aac_pkg::DEV_W-1:0]   deviation,
	output logic                        offset_captured
);
	import aac_pkg::*;

	localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
	localparam int POS_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	// Reciprocal of the window length, exact for every dividend below 2^SUM_W
	localparam int RECIP_SH = SUM_W + $clog2(WINDOW_LENGTH);
	localparam int RECIP_W  = SUM_W + 1;
	localparam int MUL_W    = SUM_W + RECIP_W;
	localparam longint RECIP_VAL = ((longint'(1) << RECIP_SH) + longint'(WINDOW_LENGTH) - 1)
	                               / longint'(WINDOW_LENGTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
	localparam int EXT_W    = SUM_W + DEV_W;

	back_state_t state_q, state_nx;

	// Window and offset state
	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_LENGTH];
	logic [SAMPLE_BITS-1:0] ring_rd_q;
	logic [POS_W-1:0]       pos_q;
	logic                   wrapped_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       offset_q;
	logic                   taken_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	// Division by the window length through a reciprocal multiply
	logic [SUM_W-1:0] div_num_q;
	logic [SUM_W-1:0] div_quo_q;
	logic [MUL_W-1:0] div_prod;
	logic             div_load;
	logic             div_step;
	logic [SUM_W-1:0] div_in;

	// Datapath helpers
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       sum_new;
	logic [SUM_W-1:0]       mean_scaled;
	logic [SUM_W-1:0]       diff;
	logic [EXT_W-1:0]       quo_ext;
	logic [DEV_W-1:0]       dev_sat;
	logic [DEV_W-1:0]       dev_q;
	logic [PROD_W-1:0]      radicand;

	// Control
	logic do_capture;
	logic do_update;
	logic sqrt_start;
	logic sqrt_busy;
	logic out_load;
	logic [SPEED_W-1:0] sqrt_root;

	// Result buffer
	logic               out_valid_q;
	logic [SPEED_W-1:0] out_speed_q;
	logic [DEV_W-1:0]   out_dev_q;
	logic               out_taken_q;

	// Entries never written since reset read as zero
	assign old_sample  = wrapped_q ? ring_rd_q : '0;
	assign sum_new     = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
	assign mean_scaled = SUM_W'(div_quo_q * WINDOW_LENGTH);
	assign diff        = (mean_scaled >= offset_q) ? (mean_scaled - offset_q)
	                                               : (offset_q - mean_scaled);
	assign quo_ext     = EXT_W'(div_quo_q);
	assign dev_sat     = (quo_ext > EXT_W'(DEV_MAX)) ? DEV_MAX : quo_ext[DEV_W-1:0];
	assign radicand    = PROD_W'(dev_sat) * PROD_W'(scale);
	assign div_prod    = MUL_W'(div_num_q) * MUL_W'(RECIP);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and control
	always_comb begin
		state_nx   = state_q;
		cmd_take   = 1'b0;
		do_capture = 1'b0;
		do_update  = 1'b0;
		div_load   = 1'b0;
		div_step   = 1'b0;
		div_in     = sum_q;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					if (cmd_capture) begin
						do_capture = 1'b1;
						div_load   = 1'b1;
						div_in     = sum_q;
						state_nx   = S_MEAN;
					end else begin
						state_nx = S_UPDATE;
					end
				end
			end
			S_UPDATE: begin
				do_update = 1'b1;
				div_load  = 1'b1;
				div_in    = sum_new;
				state_nx  = S_MEAN;
			end
			S_MEAN: begin
				div_step = 1'b1;
				state_nx = S_DIFF;
			end
			S_DIFF: begin
				div_load = 1'b1;
				div_in   = diff;
				state_nx = S_DEV;
			end
			S_DEV: begin
				div_step = 1'b1;
				state_nx = S_ROOT_LOAD;
			end
			S_ROOT_LOAD: begin
				sqrt_start = 1'b1;
				state_nx   = S_ROOT;
			end
			S_ROOT: begin
				if (!sqrt_busy) begin
					state_nx = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Sample ring memory, registered read at the current position
	always_ff @(posedge clk) begin
		if (do_update) begin
			ring_mem[pos_q] <= sample_q;
		end
		ring_rd_q <= ring_mem[pos_q];
	end

	// Window position, sum and zero offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			offset_q  <= '0;
			taken_q   <= 1'b0;
		end else begin
			if (do_capture) begin
				offset_q <= sum_q;
				taken_q  <= 1'b1;
			end
			if (do_update) begin
				sum_q <= sum_new;
				if (pos_q == POS_W'(WINDOW_LENGTH - 1)) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// Divider operand, quotient and per-item payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			sample_q <= cmd_sample;
		end
		if (div_load) begin
			div_num_q <= div_in;
		end
		if (div_step) begin
			div_quo_q <= SUM_W'(div_prod >> RECIP_SH);
		end
		if (sqrt_start) begin
			dev_q <= dev_sat;
		end
	end

	aac_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	// Result buffer
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_speed_q <= sqrt_root;
			out_dev_q   <= dev_q;
			out_taken_q <= taken_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty           = !out_valid_q;
	assign airspeed_q8_8   = out_speed_q;
	assign deviation       = out_dev_q;
	assign offset_captured = out_taken_q;

`ifndef SYNTHESIS
	// Write position stays inside the window
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(WINDOW_LENGTH - 1))
		else $error("ring position beyond window");

	// Square root unit is never restarted while it is working
	a_sqrt_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_busy)
		else $error("square root restarted while busy");

	// A waiting result is not overwritten before it is popped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(out_speed_q) && $stable(out_dev_q)))
		else $error("pending result overwritten");

	// A new command is taken only while the sequencer is idle and the square root unit is not busy
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> (state_q == S_IDLE && !sqrt_busy))
		else $error("command taken while busy");
`endif

endmodule

### design/airspeed_average_and_convert_unit.sv
// Top level of the airspeed average and convert unit: config register, front end, back end.
//
// Usage:
//   Input queue: drive action/adc_sample with push; the transaction is taken when push is
//   high and full is low. A two-entry command queue sits in front of the datapath.
//   action 0 enters a sample into the moving window, action 1 captures the window sum
//   as the zero offset. Every transaction returns exactly one result.
//   Result queue: while empty is low, airspeed_q8_8/deviation/offset_captured hold the
//   oldest result; pop with empty low takes it. A stalled reader holds one result in the
//   output buffer, one more finished result waits in the back end and up to two commands
//   queue up; then full rises.
//   Config: cfg_data is written to the scale register when cfg_valid and cfg_ready are
//   high; cfg_ready is always high. Write it only while the block is idle.
// Sequencing:
//   The back end works on one command at a time and takes a new one only from idle.
//   A sample passes the window update, two reciprocal multiplies by 1/WINDOW_LENGTH
//   (mean, then deviation) and the iterative square root; a capture skips the update.
// Reset:
//   arst_n clears the window, offset, queues and result buffer; scale returns to 5199.
module airspeed_average_and_convert_unit #(
	parameter int WINDOW_LENGTH = 20,
	parameter int SAMPLE_BITS   = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        action,
	input  logic [aac_pkg::ADC_W-1:0]   adc_sample,
	output logic                        empty,
	input  logic                        pop,
	output logic [aac_pkg::SPEED_W-1:0] airspeed_q8_8,
	output logic [aac_pkg::DEV_W-1:0]   deviation,
	output logic                        offset_captured,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [aac_pkg::SCALE_W-1:0] cfg_data
);
	import aac_pkg::*;

	logic [SCALE_W-1:0]     scale_q;
	logic                   cmd_valid;
	logic                   cmd_capture;
	logic [SAMPLE_BITS-1:0] cmd_sample;
	logic                   cmd_take;

	// Scale register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scale_q <= cfg_data;
		end
	end

	aac_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.adc_sample  (adc_sample),
		.cmd_valid   (cmd_valid),
		.cmd_capture (cmd_capture),
		.cmd_sample  (cmd_sample),
		.cmd_take    (cmd_take)
	);

	aac_back #(
		.WINDOW_LENGTH (WINDOW_LENGTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_capture     (cmd_capture),
		.cmd_sample      (cmd_sample),
		.cmd_take        (cmd_take),
		.scale           (scale_q),
		.empty           (empty),
		.pop             (pop),
		.airspeed_q8_8   (airspeed_q8_8),
		.deviation       (deviation),
		.offset_captured (offset_captured)
	);

endmodule
